// File: src/cbmm_pkg.sv
// Shared types, codes and address constants of the console bus memory map.
package cbmm_pkg;

	localparam int ROM_BYTES   = 32768;
	localparam int UPPER_BYTES = 32768;
	localparam int ROM_AW      = $clog2(ROM_BYTES);
	localparam int UPPER_AW    = $clog2(UPPER_BYTES);

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_LOAD  = 2'd2;

	localparam logic [15:0] ADDR_ROM_END   = 16'h7FFF;
	localparam logic [15:0] ADDR_ENA_END   = 16'h1FFF;
	localparam logic [15:0] ADDR_VRAM_END  = 16'h9FFF;
	localparam logic [15:0] ADDR_WRAM_END  = 16'hDFFF;
	localparam logic [15:0] ADDR_ECHO_BEG  = 16'hE000;
	localparam logic [15:0] ADDR_ECHO_END  = 16'hFDFF;
	localparam logic [15:0] ADDR_OAM_BEG   = 16'hFE00;
	localparam logic [15:0] ADDR_OAM_END   = 16'hFE9F;
	localparam logic [15:0] ADDR_UNUSE_END = 16'hFEFF;
	localparam logic [15:0] ADDR_IO_END    = 16'hFF7F;
	localparam logic [15:0] ADDR_ECHO_OFS  = 16'h2000;
	localparam logic [15:0] ADDR_LCDC      = 16'hFF40;
	localparam logic [15:0] ADDR_STAT      = 16'hFF41;
	localparam logic [15:0] ADDR_LY        = 16'hFF44;
	localparam logic [15:0] ADDR_DIV       = 16'hFF04;
	localparam logic [15:0] ADDR_NR32      = 16'hFF1C;

	localparam logic [7:0] ENABLE_KEY = 8'hA0;
	localparam logic [7:0] LCD_ON_BIT = 8'h80;
	localparam logic [7:0] HI_NIBBLE  = 8'hF0;
	localparam logic [7:0] LOCKED_VAL = 8'hFF;
	localparam logic [1:0] MODE_XFER  = 2'd3;

	typedef struct packed {
		logic                rom_re;
		logic                rom_we;
		logic [ROM_AW-1:0]   rom_addr;
		logic                up_re;
		logic                up_we;
		logic [UPPER_AW-1:0] up_addr;
		logic [7:0]          up_wdata;
		logic                force_ff;
		logic                ext_en_next;
		logic                lcdc_we;
		logic                stat_we;
	} dec_t;

	typedef struct packed {
		logic rom_rd;
		logic up_rd;
		logic force_ff;
		logic ext_en;
	} s1_ctrl_t;

endpackage

// File: src/cbmm_ifs.sv
// Valid/ready channel interfaces for bus items and their results.
interface cbmm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, func, address, write_data, input ready);
	modport sink (input valid, func, address, write_data, output ready);
endinterface

interface cbmm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       ext_ram_enabled;

	modport source (output valid, read_data, ext_ram_enabled, input ready);
	modport sink (input valid, read_data, ext_ram_enabled, output ready);
endinterface

// File: src/cbmm_ram.sv
// Generic single-port RAM with a registered, enabled read.
module cbmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: src/cbmm_clear.sv
// Sequencer that sweeps zeros through the upper store after reset.
module cbmm_clear (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          busy,
	output logic [cbmm_pkg::UPPER_AW-1:0] addr
);

	logic                          busy_q;
	logic [cbmm_pkg::UPPER_AW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;

endmodule

// File: src/cbmm_decode.sv
// Address decoder: turns one bus item into store accesses and lock decisions.
module cbmm_decode (
	input  logic                 valid,
	input  logic [1:0]           func,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	input  logic                 lcd_on,
	input  logic [1:0]           lcd_mode,
	input  logic                 ext_en,
	output cbmm_pkg::dec_t       dec
);

	logic        is_rd;
	logic        is_wr;
	logic        is_ld;
	logic        in_rom;
	logic        in_vram;
	logic        in_echo;
	logic        in_oam;
	logic [15:0] echo_addr;
	logic        wr_store;
	logic        wr_io;

	always_comb begin
		is_rd = valid && (func == cbmm_pkg::FUNC_READ);
		is_wr = valid && (func == cbmm_pkg::FUNC_WRITE);
		is_ld = valid && (func == cbmm_pkg::FUNC_LOAD);

		in_rom  = address <= cbmm_pkg::ADDR_ROM_END;
		in_vram = !in_rom && (address <= cbmm_pkg::ADDR_VRAM_END);
		in_echo = (address >= cbmm_pkg::ADDR_ECHO_BEG) && (address <= cbmm_pkg::ADDR_ECHO_END);
		in_oam  = (address >= cbmm_pkg::ADDR_OAM_BEG) && (address <= cbmm_pkg::ADDR_OAM_END);
		echo_addr = address - cbmm_pkg::ADDR_ECHO_OFS;

		wr_io = (address > cbmm_pkg::ADDR_UNUSE_END) && (address <= cbmm_pkg::ADDR_IO_END);
		wr_store = (!in_rom && (address <= cbmm_pkg::ADDR_WRAM_END)) || in_oam
			|| (address > cbmm_pkg::ADDR_IO_END)
			|| (wr_io && (address != cbmm_pkg::ADDR_LY));

		dec = '0;
		dec.ext_en_next = ext_en;
		dec.rom_addr    = address[cbmm_pkg::ROM_AW-1:0];
		dec.up_addr     = address[cbmm_pkg::UPPER_AW-1:0];
		dec.up_wdata    = write_data;

		if (is_rd) begin
			if (in_rom) begin
				dec.rom_re = 1'b1;
			end else begin
				dec.up_re = 1'b1;
				if (in_echo) begin
					dec.up_addr = echo_addr[cbmm_pkg::UPPER_AW-1:0];
				end
				if (in_vram) begin
					dec.force_ff = lcd_on && (lcd_mode == cbmm_pkg::MODE_XFER);
				end else if (in_oam) begin
					dec.force_ff = lcd_on && lcd_mode[1];
				end
			end
		end

		if (is_wr) begin
			if (address <= cbmm_pkg::ADDR_ENA_END) begin
				dec.ext_en_next = (write_data == cbmm_pkg::ENABLE_KEY);
			end
			dec.up_we = wr_store;
			if (address == cbmm_pkg::ADDR_DIV) begin
				dec.up_wdata = '0;
			end else if (address == cbmm_pkg::ADDR_NR32) begin
				// The low nibble can never leave its reset value of zero.
				dec.up_wdata = write_data & cbmm_pkg::HI_NIBBLE;
			end
			dec.lcdc_we = address == cbmm_pkg::ADDR_LCDC;
			dec.stat_we = address == cbmm_pkg::ADDR_STAT;
		end

		if (is_ld) begin
			dec.rom_we = (address < 16'(cbmm_pkg::ROM_BYTES));
		end
	end

endmodule

// File: src/console_bus_memory_map_top.sv
// Top level of the console bus memory map: decode, stores and result register.
//
//  channel | dir | payload                        | accepted when
//  in_ch   | in  | func, address, write_data      | in_ch.valid && in_ch.ready
//  out_ch  | out | read_data, ext_ram_enabled     | out_ch.valid && out_ch.ready
//
// One item per cycle unless out_ch stalls; results are presented from the output register.
// The accepting edge loads the ROM and upper store read registers; s1_adv loads the result.
// After reset all 32768 bytes of the upper store are zeroed; in_ch.ready is low meanwhile.
// A stalled result holds in the output register; one more item waits in the RAM
// read stage, after which in_ch.ready drops.
module console_bus_memory_map_top (
	input logic              clk,
	input logic              arst_n,
	cbmm_in_if.sink          in_ch,
	cbmm_out_if.source       out_ch
);

	cbmm_pkg::dec_t                 dec;
	cbmm_pkg::s1_ctrl_t             ctrl_s1;
	logic                           s1_valid_q;
	logic                           s1_adv;
	logic                           accept;
	logic                           clr_busy;
	logic [cbmm_pkg::UPPER_AW-1:0]  clr_addr;
	logic                           ext_en_q;
	logic                           lcd_on_q;
	logic [1:0]                     lcd_mode_q;
	logic                           up_we;
	logic [cbmm_pkg::UPPER_AW-1:0]  up_addr;
	logic [7:0]                     up_wdata;
	logic [7:0]                     up_rdata;
	logic [7:0]                     rom_rdata;
	logic                           out_valid_q;
	logic [7:0]                     read_data_q;
	logic                           ext_out_q;
	logic [7:0]                     rd_next;

	cbmm_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	cbmm_decode u_decode (
		.valid      (accept),
		.func       (in_ch.func),
		.address    (in_ch.address),
		.write_data (in_ch.write_data),
		.lcd_on     (lcd_on_q),
		.lcd_mode   (lcd_mode_q),
		.ext_en     (ext_en_q),
		.dec        (dec)
	);

	assign s1_adv      = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !clr_busy && (!s1_valid_q || s1_adv);
	assign accept      = in_ch.valid && in_ch.ready;

	assign up_we    = clr_busy || dec.up_we;
	assign up_addr  = clr_busy ? clr_addr : dec.up_addr;
	assign up_wdata = clr_busy ? 8'h00 : dec.up_wdata;

	cbmm_ram #(.WIDTH(8), .DEPTH(cbmm_pkg::UPPER_BYTES)) u_upper (
		.clk   (clk),
		.we    (up_we),
		.re    (dec.up_re),
		.addr  (up_addr),
		.wdata (up_wdata),
		.rdata (up_rdata)
	);

	cbmm_ram #(.WIDTH(8), .DEPTH(cbmm_pkg::ROM_BYTES)) u_rom (
		.clk   (clk),
		.we    (dec.rom_we),
		.re    (dec.rom_re),
		.addr  (dec.rom_addr),
		.wdata (in_ch.write_data),
		.rdata (rom_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_en_q   <= 1'b0;
			lcd_on_q   <= 1'b0;
			lcd_mode_q <= 2'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				ext_en_q <= dec.ext_en_next;
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (dec.lcdc_we) begin
				lcd_on_q <= |(dec.up_wdata & cbmm_pkg::LCD_ON_BIT);
			end
			if (dec.stat_we) begin
				lcd_mode_q <= dec.up_wdata[1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1.rom_rd   <= dec.rom_re;
			ctrl_s1.up_rd    <= dec.up_re;
			ctrl_s1.force_ff <= dec.force_ff;
			ctrl_s1.ext_en   <= dec.ext_en_next;
		end
	end

	always_comb begin
		if (ctrl_s1.rom_rd) begin
			rd_next = rom_rdata;
		end else if (ctrl_s1.up_rd) begin
			rd_next = ctrl_s1.force_ff ? cbmm_pkg::LOCKED_VAL : up_rdata;
		end else begin
			rd_next = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_q <= rd_next;
			ext_out_q   <= ctrl_s1.ext_en;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.read_data       = read_data_q;
	assign out_ch.ext_ram_enabled = ext_out_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ch.ready)
		else $error("item accepted during upper store clear");

	a_one_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(dec.rom_we && dec.up_we))
		else $error("one item writes both stores");

	a_lock_needs_lcd: assert property (@(posedge clk) disable iff (!arst_n)
		dec.force_ff |-> (lcd_on_q && lcd_mode_q[1]))
		else $error("read locked while LCD is off or in an open mode");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(ctrl_s1)))
		else $error("stalled read stage lost its item");

endmodule
